FILE: design/matrix_keypad_scanner_macros.svh
// Assertion macros for the keypad scanner.
// Used by modules that take clk and arst_n; no other dependencies.
`ifndef MATRIX_KEYPAD_SCANNER_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define KPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define KPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/kpd_pkg.sv
// Shared types, constants and helpers for the keypad scanner.
// No dependencies.
package kpd_pkg;

	localparam int NIBBLE_W = 4;
	localparam int KEY_W    = 5;
	localparam int DELAY_W  = 16;
	localparam int CFG_IDX_W = 2;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_EN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DLY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEXT_DLY  = 2'd3;

	localparam logic [DELAY_W-1:0] FIRST_DLY_RST = 16'd100;
	localparam logic [DELAY_W-1:0] NEXT_DLY_RST  = 16'd20;
	localparam logic [KEY_W-1:0]   KEY_NONE      = 5'd0;

	typedef struct packed {
		logic               repeat_en;
		logic               accel_en;
		logic [DELAY_W-1:0] first_dly;
		logic [DELAY_W-1:0] next_dly;
	} kpd_cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0]   last_key;
		logic               released;
		logic [DELAY_W-1:0] hold_count;
		logic [DELAY_W-1:0] repeat_limit;
	} kpd_state_t;

	typedef struct packed {
		logic [NIBBLE_W-1:0] row_sample;
		logic [NIBBLE_W-1:0] line_second;
		logic [NIBBLE_W-1:0] line_first;
	} kpd_sample_t;

	function automatic logic one_hot4(input logic [NIBBLE_W-1:0] v);
		one_hot4 = (v != '0) && ((v & (v - 4'd1)) == '0);
	endfunction

	// lowest set bit position
	function automatic logic [1:0] bit_index4(input logic [NIBBLE_W-1:0] v);
		if (v[0])
			bit_index4 = 2'd0;
		else if (v[1])
			bit_index4 = 2'd1;
		else if (v[2])
			bit_index4 = 2'd2;
		else if (v[3])
			bit_index4 = 2'd3;
		else
			bit_index4 = 2'd0;
	endfunction

endpackage

FILE: design/kpd_decode.sv
// Decode of one keypad scan sample and the next repeat/release state.
// Depends on kpd_pkg.
module kpd_decode (
	input  kpd_pkg::kpd_sample_t     sample,
	input  kpd_pkg::kpd_cfg_t        cfg,
	input  kpd_pkg::kpd_state_t      state_cur,
	output kpd_pkg::kpd_state_t      state_nxt,
	output logic [kpd_pkg::KEY_W-1:0] key_code
);

	logic [kpd_pkg::KEY_W-1:0]   key;
	logic [kpd_pkg::DELAY_W-1:0] hold_inc;

	assign key = {1'b0, kpd_pkg::bit_index4(sample.line_first), 2'b00}
		+ {3'b000, kpd_pkg::bit_index4(sample.row_sample)} + 5'd1;
	assign hold_inc = state_cur.hold_count + 16'd1;

	always_comb begin
		state_nxt = state_cur;
		key_code  = kpd_pkg::KEY_NONE;
		if (sample.line_first != sample.line_second) begin
			state_nxt.hold_count = '0;
		end else if (sample.line_first == '0) begin
			state_nxt.hold_count   = '0;
			state_nxt.released     = 1'b1;
			state_nxt.repeat_limit = cfg.first_dly;
		end else if (!kpd_pkg::one_hot4(sample.line_first)
				|| !kpd_pkg::one_hot4(sample.row_sample)) begin
			state_nxt.hold_count = '0;
		end else if (key != state_cur.last_key) begin
			state_nxt.last_key = key;
			state_nxt.released = 1'b0;
			key_code           = key;
		end else if (cfg.repeat_en) begin
			state_nxt.hold_count = hold_inc;
			if (hold_inc > state_cur.repeat_limit) begin
				state_nxt.hold_count = '0;
				if (cfg.accel_en && state_cur.repeat_limit == cfg.first_dly)
					state_nxt.repeat_limit = cfg.next_dly;
				key_code = key;
			end
		end else begin
			state_nxt.hold_count = '0;
			if (state_cur.released) begin
				state_nxt.released = 1'b0;
				key_code           = key;
			end
		end
	end

endmodule

FILE: design/matrix_keypad_scanner.sv
// Top level of the 4x4 keypad scanner with auto-repeat.
// Depends on kpd_pkg, kpd_decode and matrix_keypad_scanner_macros.svh.
//
//   channel  | direction | payload
//   s_*      | in        | tdata: line_first, line_second, row_sample
//   m_*      | out       | tdata: key_code
//   cfg_*    | in        | cfg_index, cfg_data
//
// One sample per clock sustained while the output is not stalled. A request is
// registered at the input stage, decoded against the key state and written to
// the output register. Reset restores the register defaults and the key state.
// A stalled output holds the input stage; s_tready then drops once it is full.
`include "matrix_keypad_scanner_macros.svh"

module matrix_keypad_scanner (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [3:0] line_first, [7:4] line_second, [11:8] row_sample, [15:12] zero
	input  logic [kpd_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [4:0] key_code, [7:5] zero
	output logic [kpd_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kpd_pkg::DELAY_W-1:0]      cfg_data
);

	kpd_pkg::kpd_cfg_t    cfg_q;
	kpd_pkg::kpd_state_t  state_q;
	kpd_pkg::kpd_state_t  state_nxt;
	kpd_pkg::kpd_sample_t sample_s1;
	logic                 valid_s1;
	logic                 advance;
	logic [kpd_pkg::KEY_W-1:0] key_nxt;
	logic [kpd_pkg::KEY_W-1:0] key_s2;
	logic                 valid_s2;

	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = {3'b000, key_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_en <= 1'b1;
			cfg_q.accel_en  <= 1'b1;
			cfg_q.first_dly <= kpd_pkg::FIRST_DLY_RST;
			cfg_q.next_dly  <= kpd_pkg::NEXT_DLY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				kpd_pkg::CFG_REPEAT_EN: cfg_q.repeat_en <= cfg_data[0];
				kpd_pkg::CFG_ACCEL_EN:  cfg_q.accel_en  <= cfg_data[0];
				kpd_pkg::CFG_FIRST_DLY: cfg_q.first_dly <= cfg_data;
				kpd_pkg::CFG_NEXT_DLY:  cfg_q.next_dly  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			sample_s1 <= s_tdata[3*kpd_pkg::NIBBLE_W-1:0];
	end

	kpd_decode u_decode (
		.sample    (sample_s1),
		.cfg       (cfg_q),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.key_code  (key_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_key     <= kpd_pkg::KEY_NONE;
			state_q.released     <= 1'b1;
			state_q.hold_count   <= '0;
			state_q.repeat_limit <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			key_s2 <= key_nxt;
	end

	`KPD_ASSERT_NOW(a_key_range, m_tvalid, m_tdata <= 8'd16, "key_code out of range")
	`KPD_ASSERT_NEXT(a_s1_hold, valid_s1 && valid_s2 && !m_tready, valid_s1,
		"input stage dropped while output stalled")
	`KPD_ASSERT_NOW(a_release_report, $fell(state_q.released),
		m_tvalid && m_tdata != 8'd0, "released cleared without a key report")
	`KPD_ASSERT_NOW(a_last_key_range, 1'b1, state_q.last_key <= 5'd16,
		"last key out of range")

endmodule

FILE: tb/testbench.sv
// Self-checking bench for matrix_keypad_scanner: a table of directed scan samples,
// then random key hold/release sequences over several register settings.
// Depends on kpd_pkg and the matrix_keypad_scanner RTL.
module testbench;
	import kpd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 110;

	typedef struct packed {
		logic [NIBBLE_W-1:0] line_a;
		logic [NIBBLE_W-1:0] line_b;
		logic [NIBBLE_W-1:0] row;
		logic                typed;
		logic [KEY_W-1:0]    key;
	} scan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [DELAY_W-1:0]     cfg_data = '0;

	// scanner shadow
	kpd_cfg_t           cfg_shadow;
	logic [KEY_W-1:0]   last_key;
	logic               released;
	logic [DELAY_W-1:0] hold_cnt;
	logic [DELAY_W-1:0] repeat_lim;

	logic [KEY_W-1:0] key_queue [$];
	int               errors = 0;
	bit               idle_on = 1'b1;
	int               sink_wait = 0;
	int               quiet_cycles = 0;
	scan_row_t        directed_rows [16];
	kpd_cfg_t         settings [9];

	matrix_keypad_scanner DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int lowest_pin(input logic [NIBBLE_W-1:0] v);
		for (int i = 0; i < NIBBLE_W; i++) begin
			if (v[i])
				return i;
		end
		return 0;
	endfunction

	function automatic logic [KEY_W-1:0] scan_key(input logic [NIBBLE_W-1:0] la,
			input logic [NIBBLE_W-1:0] lb, input logic [NIBBLE_W-1:0] row);
		logic [KEY_W-1:0] code;
		logic [KEY_W-1:0] key;
		code = KEY_NONE;
		if (la != lb) begin
			hold_cnt = '0;
		end else if (la == '0) begin
			hold_cnt = '0;
			released = 1'b1;
			repeat_lim = cfg_shadow.first_dly;
		end else if ($countones(la) != 1 || $countones(row) != 1) begin
			hold_cnt = '0;
		end else begin
			key = KEY_W'(lowest_pin(la) * 4 + lowest_pin(row) + 1);
			if (key != last_key) begin
				last_key = key;
				released = 1'b0;
				code = key;
			end else if (cfg_shadow.repeat_en) begin
				hold_cnt = hold_cnt + 1'b1;
				if (hold_cnt > repeat_lim) begin
					hold_cnt = '0;
					if (cfg_shadow.accel_en && repeat_lim == cfg_shadow.first_dly)
						repeat_lim = cfg_shadow.next_dly;
					code = key;
				end
			end else begin
				hold_cnt = '0;
				if (released) begin
					released = 1'b0;
					code = key;
				end
			end
		end
		return code;
	endfunction

	// mostly short gaps, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_sample(input logic [NIBBLE_W-1:0] la, input logic [NIBBLE_W-1:0] lb,
			input logic [NIBBLE_W-1:0] row, input logic typed, input logic [KEY_W-1:0] key);
		int gap;
		logic [KEY_W-1:0] predicted;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, row, lb, la};
		do @(posedge clk); while (!s_tready);
		predicted = scan_key(la, lb, row);
		key_queue.push_back(typed ? key : predicted);
	endtask

	task automatic wait_drained();
		while (key_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input kpd_cfg_t s);
		logic [CFG_IDX_W-1:0] idx [4];
		idx[0] = CFG_REPEAT_EN;
		idx[1] = CFG_ACCEL_EN;
		idx[2] = CFG_FIRST_DLY;
		idx[3] = CFG_NEXT_DLY;
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			case (idx[i])
				CFG_REPEAT_EN: cfg_data <= DELAY_W'(s.repeat_en);
				CFG_ACCEL_EN:  cfg_data <= DELAY_W'(s.accel_en);
				CFG_FIRST_DLY: cfg_data <= s.first_dly;
				default:       cfg_data <= s.next_dly;
			endcase
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cfg_shadow = s;
	endtask

	// one phase of random key activity
	task automatic run_phase(input int count);
		int sent;
		int hold_len;
		int kind;
		logic [NIBBLE_W-1:0] line;
		logic [NIBBLE_W-1:0] row;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				line = 4'b1 << $urandom_range(0, 3);
				row = 4'b1 << $urandom_range(0, 3);
				hold_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				for (int i = 0; i < hold_len; i++) begin
					if ($urandom_range(0, 7) == 0)
						send_sample(line, 4'($urandom_range(0, 15)) ^ line, row, 1'b0, KEY_NONE);
					else
						send_sample(line, line, row, 1'b0, KEY_NONE);
					sent++;
				end
				if ($urandom_range(0, 1) == 0) begin
					send_sample(4'h0, 4'h0, 4'($urandom_range(0, 15)), 1'b0, KEY_NONE);
					sent++;
				end
			end else if (kind == 7) begin
				send_sample(4'h0, 4'h0, 4'($urandom_range(0, 15)), 1'b0, KEY_NONE);
				sent++;
			end else begin
				send_sample(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)), 1'b0, KEY_NONE);
				sent++;
			end
		end
		s_tvalid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			sink_wait <= pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (key_queue.size() == 0) begin
				$display("%0t: key_code %0d with none expected", $time, m_tdata[KEY_W-1:0]);
				errors++;
			end else if (m_tdata[KEY_W-1:0] !== key_queue[0]) begin
				$display("%0t: key_code expected %0d, got %0d", $time, key_queue[0],
					m_tdata[KEY_W-1:0]);
				errors++;
				void'(key_queue.pop_front());
			end else begin
				void'(key_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		cfg_shadow = '{repeat_en: 1'b1, accel_en: 1'b1, first_dly: FIRST_DLY_RST,
			next_dly: NEXT_DLY_RST};
		last_key = KEY_NONE;
		released = 1'b1;
		hold_cnt = '0;
		repeat_lim = '0;

		directed_rows = '{
			'{4'h1, 4'h1, 4'h1, 1'b1, 5'd1},   // first key after reset
			'{4'h1, 4'h1, 4'h1, 1'b0, KEY_NONE},
			'{4'h1, 4'h2, 4'h1, 1'b1, KEY_NONE}, // line reads disagree
			'{4'h0, 4'h0, 4'h0, 1'b1, KEY_NONE}, // release
			'{4'h3, 4'h3, 4'h1, 1'b1, KEY_NONE}, // two lines
			'{4'h4, 4'h4, 4'h0, 1'b1, KEY_NONE}, // no row
			'{4'h4, 4'h4, 4'h6, 1'b1, KEY_NONE}, // two rows
			'{4'h8, 4'h8, 4'h8, 1'b1, 5'd16},
			'{4'hf, 4'hf, 4'hf, 1'b1, KEY_NONE},
			'{4'h8, 4'h8, 4'h8, 1'b0, KEY_NONE},
			'{4'h0, 4'hf, 4'hf, 1'b1, KEY_NONE},
			'{4'hf, 4'h0, 4'h0, 1'b1, KEY_NONE},
			'{4'h2, 4'h2, 4'h4, 1'b1, 5'd7},
			'{4'h4, 4'h4, 4'h2, 1'b1, 5'd10},
			'{4'h1, 4'h1, 4'h8, 1'b1, 5'd4},
			'{4'h8, 4'h8, 4'h1, 1'b1, 5'd13}
		};

		settings[0] = '{1'b1, 1'b1, 16'd3, 16'd1};
		settings[1] = '{1'b1, 1'b0, 16'd2, 16'd65535};
		settings[2] = '{1'b0, 1'b1, 16'd100, 16'd20};
		settings[3] = '{1'b1, 1'b1, 16'd0, 16'd0};
		settings[4] = '{1'b1, 1'b1, 16'd65535, 16'd65535};
		settings[5] = '{1'b0, 1'b0, 16'd65535, 16'd0};
		settings[6] = '{1'b1, 1'b1, 16'd5, 16'd2};
		for (int i = 7; i < 9; i++) begin
			settings[i] = '{1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				16'($urandom_range(0, 8)), 16'($urandom_range(0, 8))};
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_sample(directed_rows[i].line_a, directed_rows[i].line_b, directed_rows[i].row,
				directed_rows[i].typed, directed_rows[i].key);
		end
		s_tvalid <= 1'b0;

		foreach (settings[i]) begin
			apply_settings(settings[i]);
			idle_on = (i % 3) != 1;
			run_phase(PHASE_ITEMS);
		end

		wait_drained();
		if (errors == 0 && key_queue.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/kpd_pkg.sv
design/kpd_decode.sv
design/matrix_keypad_scanner.sv
tb/testbench.sv
